[sv/positional_pid_controller_core_assert.svh]
// Assertion shorthands for the PID core. Both expect clk and rst_n in scope.
`ifndef POSITIONAL_PID_CONTROLLER_CORE_ASSERT_SVH
`define POSITIONAL_PID_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication.
`define PPC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppc assertion failed");

// Next-cycle implication.
`define PPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppc assertion failed");

`endif

[sv/ppc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ppc_pkg;

  localparam int DATA_W_DEF = 16;
  localparam int SUM_W_DEF  = 32;
  localparam int GAIN_W     = 32;
  localparam int Q_DEPTH    = 2;

  // Each term saturates at 2^60 in magnitude; three of them fit 63 bits.
  localparam int TERM_SHIFT = 60;
  localparam int TERM_W     = TERM_SHIFT + 2;
  localparam int TOT_W      = TERM_W + 1;

  localparam logic signed [TERM_W-1:0] TERM_POS = {2'b01, {TERM_SHIFT{1'b0}}};
  localparam logic signed [TERM_W-1:0] TERM_NEG = -TERM_POS;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] MODE_P  = 2'd0;
  localparam logic [1:0] MODE_PI = 2'd1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MAX   = 2'd1;
  localparam logic [1:0] ST_FLOOR = 2'd2;

  localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd3;
  localparam logic [2:0] REG_LOOP_MODE     = 3'd4;
  localparam logic [2:0] REG_OUT_MAX       = 3'd5;
  localparam logic [2:0] REG_OUT_FLOOR     = 3'd6;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integral_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [1:0]        loop_mode;
    logic [15:0]       out_max;
    logic [15:0]       out_floor;
  } back_cfg_t;

endpackage
`default_nettype wire

[sv/ppc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module ppc_queue import ppc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = Q_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

[sv/ppc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module ppc_front import ppc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_W_DEF,
  parameter int SUM_WIDTH  = SUM_W_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_cmd,
  input  wire logic [DATA_WIDTH-1:0] in_setpoint,
  input  wire logic [DATA_WIDTH-1:0] in_measured,
  input  wire logic [15:0]           sample_period,
  input  wire logic                  q_full,
  output logic                       q_push,
  output logic [(DATA_WIDTH+1)+SUM_WIDTH+(DATA_WIDTH+2)-1:0] q_wdata
);

  localparam int EW = DATA_WIDTH + 1;
  localparam int XW = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;
  localparam logic signed [XW-1:0] SUM_MAX =
    {{(XW-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [XW-1:0] SUM_MIN = ~SUM_MAX;

  logic signed [SUM_WIDTH-1:0] error_sum_r, error_sum_nxt;
  logic signed [EW-1:0]        last_err_r, last_err_nxt;
  logic [15:0]                 tick_count_r, tick_count_nxt;

  logic signed [EW-1:0]   err;
  logic signed [EW:0]     diff;
  logic signed [XW-1:0]   sum_x;
  logic                   accept, due;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign due      = (tick_count_r >= sample_period);
  assign q_push   = accept && (in_cmd == CMD_SAMPLE) && due;

  assign err   = EW'($signed(in_setpoint)) - EW'($signed(in_measured));
  assign diff  = (EW+1)'(err) - (EW+1)'(last_err_r);
  assign sum_x = XW'(error_sum_r) + XW'(err);

  always_comb begin
    if (sum_x > SUM_MAX) begin
      error_sum_nxt = SUM_MAX[SUM_WIDTH-1:0];
    end else if (sum_x < SUM_MIN) begin
      error_sum_nxt = SUM_MIN[SUM_WIDTH-1:0];
    end else begin
      error_sum_nxt = sum_x[SUM_WIDTH-1:0];
    end
  end

  assign q_wdata = {err, error_sum_nxt, diff};

  always_comb begin
    tick_count_nxt = tick_count_r;
    last_err_nxt   = last_err_r;
    if (accept && in_cmd == CMD_TICK) begin
      if (tick_count_r != TICK_MAX) begin
        tick_count_nxt = tick_count_r + 1'b1;
      end
    end else if (q_push) begin
      tick_count_nxt = '0;
      last_err_nxt   = err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_err_r   <= '0;
      tick_count_r <= '0;
    end else begin
      tick_count_r <= tick_count_nxt;
      last_err_r   <= last_err_nxt;
      if (q_push) begin
        error_sum_r <= error_sum_nxt;
      end
    end
  end

endmodule
`default_nettype wire

[sv/ppc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "positional_pid_controller_core_assert.svh"
module ppc_back import ppc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_W_DEF,
  parameter int SUM_WIDTH  = SUM_W_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire back_cfg_t cfg,
  input  wire logic      q_empty,
  input  wire logic [(DATA_WIDTH+1)+SUM_WIDTH+(DATA_WIDTH+2)-1:0] q_rdata,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [15:0]    out_drive,
  output logic [1:0]     out_limit_status
);

  localparam int EW   = DATA_WIDTH + 1;
  localparam int OPW  = (SUM_WIDTH > EW + 1) ? SUM_WIDTH : EW + 1;
  localparam int LO_W = OPW / 2;
  localparam int HI_W = OPW - LO_W;
  localparam int PLW  = GAIN_W + LO_W;
  localparam int PHW  = GAIN_W + HI_W + 1;
  localparam int PW   = OPW + GAIN_W + 1;
  localparam int CW   = (PW > TERM_W) ? PW : TERM_W;
  localparam logic signed [CW-1:0] TLIM_POS = CW'(TERM_POS);
  localparam logic signed [CW-1:0] TLIM_NEG = CW'(TERM_NEG);

  logic signed [EW-1:0]        q_err;
  logic signed [SUM_WIDTH-1:0] q_sum;
  logic signed [EW:0]          q_diff;
  logic signed [OPW-1:0]       op   [3];
  logic [GAIN_W-1:0]           gain [3];

  logic                       adv;
  logic                       v1_r, v2_r, v3_r, out_valid_r;
  logic [PLW-1:0]             pl_r   [3];
  logic [PLW-1:0]             pl_nxt [3];
  logic signed [PHW-1:0]      ph_r   [3];
  logic signed [PHW-1:0]      ph_nxt [3];
  logic signed [TERM_W-1:0]   term_r   [3];
  logic signed [TERM_W-1:0]   term_nxt [3];
  logic signed [CW-1:0]       prod [3];
  logic signed [TOT_W-1:0]    total_r, total_nxt;
  logic signed [TOT_W-1:0]    limit;
  logic [15:0]                drive_r, drive_nxt;
  logic [1:0]                 status_r, status_nxt;
  logic                       use_i, use_d;
  logic                       terms_in_range;

  assign {q_err, q_sum, q_diff} = q_rdata;

  // The whole pipe moves together while the output word is free or taken.
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && !q_empty;

  assign op[0]   = OPW'(q_err);
  assign op[1]   = OPW'(q_sum);
  assign op[2]   = OPW'(q_diff);
  assign gain[0] = cfg.prop_gain;
  assign gain[1] = cfg.integral_gain;
  assign gain[2] = cfg.deriv_gain;

  assign use_i = (cfg.loop_mode != MODE_P);
  assign use_d = (cfg.loop_mode != MODE_P) && (cfg.loop_mode != MODE_PI);

  // Split each operand in halves: unsigned low times gain, signed high times gain.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pl_nxt[k] = PLW'(gain[k]) * PLW'(op[k][LO_W-1:0]);
      ph_nxt[k] = $signed({1'b0, gain[k]}) * $signed(op[k][OPW-1:LO_W]);
    end
  end

  // Recombine, saturate each term at 2^60, drop terms the mode excludes.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = (CW'(ph_r[k]) <<< LO_W) + CW'($signed({1'b0, pl_r[k]}));
      if (prod[k] > TLIM_POS) begin
        term_nxt[k] = TERM_POS;
      end else if (prod[k] < TLIM_NEG) begin
        term_nxt[k] = TERM_NEG;
      end else begin
        term_nxt[k] = prod[k][TERM_W-1:0];
      end
    end
    if (!use_i) begin
      term_nxt[1] = '0;
    end
    if (!use_d) begin
      term_nxt[2] = '0;
    end
  end

  assign total_nxt = TOT_W'(term_r[0]) + TOT_W'(term_r[1]) + TOT_W'(term_r[2]);
  assign limit     = $signed({{(TOT_W-32){1'b0}}, cfg.out_max, 16'h0000});

  always_comb begin
    if (total_r > limit) begin
      drive_nxt  = cfg.out_max;
      status_nxt = ST_MAX;
    end else if (total_r[TOT_W-1]) begin
      drive_nxt  = cfg.out_floor;
      status_nxt = ST_FLOOR;
    end else begin
      drive_nxt  = total_r[31:16];
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= !q_empty;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pl_r[k]   <= pl_nxt[k];
        ph_r[k]   <= ph_nxt[k];
        term_r[k] <= term_nxt[k];
      end
      total_r  <= total_nxt;
      drive_r  <= drive_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive        = drive_r;
  assign out_limit_status = status_r;

  assign terms_in_range = (term_r[0] <= TERM_POS) && (term_r[0] >= TERM_NEG) &&
                          (term_r[1] <= TERM_POS) && (term_r[1] >= TERM_NEG) &&
                          (term_r[2] <= TERM_POS) && (term_r[2] >= TERM_NEG);

  `PPC_ASSERT(a_pop_nonempty, q_pop, !q_empty)
  `PPC_ASSERT(a_term_bound, v2_r, terms_in_range)
  `PPC_ASSERT_NEXT(a_stall_hold, v3_r && !adv, v3_r && $stable(total_r))
  `PPC_ASSERT_NEXT(a_drain, v3_r && adv, out_valid_r)

endmodule
`default_nettype wire

[sv/positional_pid_controller_core.sv]
// Positional PID controller core.
// Input channel (in_valid/in_ready): in_cmd selects a timer tick or a sample.
// A tick advances a saturating elapsed counter. A sample with in_setpoint and
// in_measured is dropped, with no result, until the counter reaches
// sample_period; otherwise it clears the counter, updates the error sum and
// last error, and yields one result word on out_valid/out_ready.
// Configuration: write cfg_data to register cfg_index while cfg_we is high.
// Path: an accepted sample word passes the queue, then the partial product,
// term, total and clamp registers before its result is valid.
// Throughput: one word per cycle while in_ready is high, ticks and samples
// alike; the front updates the loop state in the accept cycle, the back runs
// a four-stage multiply and clamp pipeline behind a two-entry queue.
// Receiver stall: the back pipe freezes; the queue fills and then in_ready
// drops until the result word is taken.
// Reset: synchronous, active low; clears state and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none
module positional_pid_controller_core import ppc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_W_DEF,
  parameter int SUM_WIDTH  = SUM_W_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [GAIN_W-1:0]     cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_cmd,
  input  wire logic [DATA_WIDTH-1:0] in_setpoint,
  input  wire logic [DATA_WIDTH-1:0] in_measured,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [15:0]                out_drive,
  output logic [1:0]                 out_limit_status
);

  localparam int QW = (DATA_WIDTH + 1) + SUM_WIDTH + (DATA_WIDTH + 2);

  back_cfg_t   cfg_r;
  logic [15:0] sample_period_r;

  logic          q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= 32'd32768;
      cfg_r.integral_gain <= 32'd182;
      cfg_r.deriv_gain    <= 32'd32768;
      cfg_r.loop_mode     <= 2'd2;
      cfg_r.out_max       <= 16'd330;
      cfg_r.out_floor     <= 16'd0;
      sample_period_r     <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:     cfg_r.prop_gain     <= cfg_data;
        REG_INTEGRAL_GAIN: cfg_r.integral_gain <= cfg_data;
        REG_DERIV_GAIN:    cfg_r.deriv_gain    <= cfg_data;
        REG_SAMPLE_PERIOD: sample_period_r     <= cfg_data[15:0];
        REG_LOOP_MODE:     cfg_r.loop_mode     <= cfg_data[1:0];
        REG_OUT_MAX:       cfg_r.out_max       <= cfg_data[15:0];
        REG_OUT_FLOOR:     cfg_r.out_floor     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  ppc_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_setpoint  (in_setpoint),
    .in_measured  (in_measured),
    .sample_period(sample_period_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  ppc_queue #(
    .WIDTH(QW),
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  ppc_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_drive       (out_drive),
    .out_limit_status(out_limit_status)
  );

endmodule
`default_nettype wire
